/* rtl/adts_frame_deframer_core_macros.svh */
// Assertion macros shared by the ADTS deframer RTL.
// Pulled in by the modules that carry concurrent checks; no other dependencies.
`ifndef ADTS_FRAME_DEFRAMER_CORE_MACROS_SVH
`define ADTS_FRAME_DEFRAMER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ADF_CHECK_IMPLY(label, clk, rst, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error("%m: implication check failed");

// Next-cycle implication, disabled while reset is high.
`define ADF_CHECK_NEXT(label, clk, rst, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error("%m: next-cycle check failed");

`endif

/* rtl/adf_pkg.sv */
// Shared types, constants and the sampling rate table of the ADTS deframer.
// No dependencies; the other RTL module files refer to it by scoped names.
`timescale 1ns / 1ps

package adf_pkg;

  // Result kinds
  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_ABORT   = 2'd1;
  localparam logic [1:0] KIND_EOS     = 2'd2;

  // Header sync and sizes
  localparam logic [7:0]  SYNC_BYTE     = 8'hFF;
  localparam logic [7:0]  SYNC_MASK     = 8'hF0;
  localparam logic [12:0] HDR_SHORT_LEN = 13'd7;
  localparam logic [12:0] HDR_LONG_LEN  = 13'd9;

  // Look-ahead window: seven stored bytes plus the incoming one
  localparam int WIN_DEPTH = 7;
  localparam int WIN_IDX_W = $clog2(WIN_DEPTH);
  localparam logic [WIN_IDX_W-1:0] WIN_FULL = WIN_IDX_W'(WIN_DEPTH);

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int OUT_TDATA_W = 56;

  // One accepted input byte, classified: up to three results
  typedef struct packed {
    logic        has_pay;
    logic        abort;
    logic        eos;
    logic [7:0]  payload_byte;
    logic        first_of_frame;
    logic        last_of_frame;
    logic [12:0] payload_length;
    logic        info_valid;
    logic [2:0]  object_type;
    logic [3:0]  rate_index;
    logic [2:0]  channel_setup;
  } adf_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } adf_qstat_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  payload_byte;
    logic        first_of_frame;
    logic        last_of_frame;
    logic [12:0] payload_length;
    logic        info_valid;
    logic [2:0]  object_type;
    logic [3:0]  rate_index;
    logic [2:0]  channel_setup;
    logic [16:0] freq_hz;
    logic        run_last;
  } adf_result_t;

  function automatic logic [16:0] rate_of(input logic [3:0] idx);
    logic [16:0] r;
    unique case (idx)
      4'd0:    r = 17'd96000;
      4'd1:    r = 17'd88200;
      4'd2:    r = 17'd64000;
      4'd3:    r = 17'd48000;
      4'd4:    r = 17'd44100;
      4'd5:    r = 17'd32000;
      4'd6:    r = 17'd24000;
      4'd7:    r = 17'd22050;
      4'd8:    r = 17'd16000;
      4'd9:    r = 17'd12000;
      4'd10:   r = 17'd11025;
      4'd11:   r = 17'd8000;
      4'd12:   r = 17'd7350;
      default: r = 17'd0;
    endcase
    return r;
  endfunction

endpackage

/* rtl/adf_queue.sv */
// Short command queue between the deframer front and back.
// Depends on adf_pkg for the command type and depth.
`timescale 1ns / 1ps

module adf_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  adf_pkg::adf_cmd_t wr_cmd,
  input  logic              pop,
  output adf_pkg::adf_cmd_t head,
  output adf_pkg::adf_qstat_t qstat
);

  adf_pkg::adf_cmd_t mem [adf_pkg::QUEUE_DEPTH];
  logic [adf_pkg::QPTR_W-1:0] wr_ptr;
  logic [adf_pkg::QPTR_W-1:0] rd_ptr;
  logic [adf_pkg::QCNT_W-1:0] count;
  logic do_push;
  logic do_pop;

  assign qstat.full  = (count == adf_pkg::QCNT_W'(adf_pkg::QUEUE_DEPTH));
  assign qstat.empty = (count == '0);
  assign do_push = push && !qstat.full;
  assign do_pop  = pop && !qstat.empty;
  assign head    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* rtl/adf_front.sv */
// Front of the deframer: window, sync search, header skip, at most one command per byte.
// Depends on adf_pkg and the shared assertion macros header.
`timescale 1ns / 1ps
`include "adts_frame_deframer_core_macros.svh"

module adf_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_byte,
  input  logic                end_of_buffer,
  input  adf_pkg::adf_qstat_t qstat,
  output logic                push,
  output adf_pkg::adf_cmd_t   cmd
);

  logic [7:0] win [adf_pkg::WIN_DEPTH];
  logic [adf_pkg::WIN_IDX_W-1:0] fill, fill_next;
  logic        in_frame, in_frame_next;
  logic        hdr_skip, hdr_skip_next;
  logic [12:0] payload_left, payload_left_next;
  logic        seen, seen_next;
  logic        first_pending, first_pending_next;
  logic [1:0]  held_profile, held_profile_next;
  logic [3:0]  held_idx, held_idx_next;
  logic [2:0]  held_ch, held_ch_next;

  logic        accept;
  logic        win_write, win_shift;
  logic [12:0] frame_len, body_len;
  logic        sync_ok, short_hdr, frame_ok;
  logic [1:0]  win_profile;
  logic [3:0]  win_idx;
  logic [2:0]  win_ch;

  assign in_ready = !qstat.full;
  assign accept   = in_valid && in_ready;

  // Judge the oldest byte: window bytes 0..5 carry sync and length
  assign frame_len   = {win[3][1:0], win[4], win[5][7:5]};
  assign sync_ok     = (win[0] == adf_pkg::SYNC_BYTE) &&
                       ((win[1] & adf_pkg::SYNC_MASK) == adf_pkg::SYNC_MASK);
  assign short_hdr   = win[1][0];
  assign frame_ok    = sync_ok && (short_hdr ? (frame_len > adf_pkg::HDR_SHORT_LEN)
                                             : (frame_len > adf_pkg::HDR_LONG_LEN));
  assign body_len    = frame_len - (short_hdr ? adf_pkg::HDR_SHORT_LEN
                                              : adf_pkg::HDR_LONG_LEN);
  assign win_profile = win[2][7:6];
  assign win_idx     = win[2][5:2];
  assign win_ch      = {win[2][0], win[3][7:6]};

  always_comb begin
    fill_next          = fill;
    in_frame_next      = in_frame;
    hdr_skip_next      = hdr_skip;
    payload_left_next  = payload_left;
    seen_next          = seen;
    first_pending_next = first_pending;
    held_profile_next  = held_profile;
    held_idx_next      = held_idx;
    held_ch_next       = held_ch;
    win_write          = 1'b0;
    win_shift          = 1'b0;
    cmd                = '0;

    if (in_frame) begin
      // Window is empty while a frame is open: the byte passes straight through
      if (hdr_skip) begin
        hdr_skip_next = 1'b0;
      end else begin
        cmd.has_pay       = 1'b1;
        cmd.payload_byte  = in_byte;
        payload_left_next = payload_left - 1'b1;
        if (first_pending) begin
          cmd.first_of_frame = 1'b1;
          cmd.payload_length = payload_left;
          first_pending_next = 1'b0;
          if (!seen) begin
            cmd.info_valid    = 1'b1;
            cmd.object_type   = {1'b0, held_profile} + 3'd1;
            cmd.rate_index    = held_idx;
            cmd.channel_setup = held_ch;
            seen_next         = 1'b1;
          end
        end
        if (payload_left == 13'd1) begin
          cmd.last_of_frame = 1'b1;
          in_frame_next     = 1'b0;
        end
      end
    end else if (fill == adf_pkg::WIN_FULL) begin
      if (!frame_ok) begin
        win_shift = 1'b1;
      end else begin
        // Frame found: the whole window is header except possibly the new byte
        fill_next         = '0;
        held_profile_next = win_profile;
        held_idx_next     = win_idx;
        held_ch_next      = win_ch;
        if (short_hdr) begin
          cmd.has_pay        = 1'b1;
          cmd.payload_byte   = in_byte;
          cmd.first_of_frame = 1'b1;
          cmd.payload_length = body_len;
          payload_left_next  = body_len - 1'b1;
          first_pending_next = 1'b0;
          if (!seen) begin
            cmd.info_valid    = 1'b1;
            cmd.object_type   = {1'b0, win_profile} + 3'd1;
            cmd.rate_index    = win_idx;
            cmd.channel_setup = win_ch;
            seen_next         = 1'b1;
          end
          if (body_len == 13'd1) begin
            cmd.last_of_frame = 1'b1;
          end else begin
            in_frame_next = 1'b1;
          end
        end else begin
          in_frame_next      = 1'b1;
          hdr_skip_next      = 1'b1;
          payload_left_next  = body_len;
          first_pending_next = 1'b1;
        end
      end
    end else begin
      win_write = 1'b1;
      fill_next = fill + 1'b1;
    end

    if (end_of_buffer) begin
      cmd.abort          = in_frame_next;
      cmd.eos            = 1'b1;
      fill_next          = '0;
      in_frame_next      = 1'b0;
      hdr_skip_next      = 1'b0;
      payload_left_next  = '0;
      seen_next          = 1'b0;
      first_pending_next = 1'b0;
    end
  end

  assign push = accept && (cmd.has_pay || end_of_buffer);

  always_ff @(posedge clk) begin
    if (accept && win_write) begin
      win[fill] <= in_byte;
    end else if (accept && win_shift) begin
      for (int i = 0; i < adf_pkg::WIN_DEPTH - 1; i++) begin
        win[i] <= win[i+1];
      end
      win[adf_pkg::WIN_DEPTH-1] <= in_byte;
    end
    if (accept) begin
      held_profile <= held_profile_next;
      held_idx     <= held_idx_next;
      held_ch      <= held_ch_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill          <= '0;
      in_frame      <= 1'b0;
      hdr_skip      <= 1'b0;
      payload_left  <= '0;
      seen          <= 1'b0;
      first_pending <= 1'b0;
    end else if (accept) begin
      fill          <= fill_next;
      in_frame      <= in_frame_next;
      hdr_skip      <= hdr_skip_next;
      payload_left  <= payload_left_next;
      seen          <= seen_next;
      first_pending <= first_pending_next;
    end
  end

  `ADF_CHECK_IMPLY(a_frame_window_empty, clk, rst, in_frame, fill == '0)
  `ADF_CHECK_IMPLY(a_skip_before_first, clk, rst, hdr_skip, in_frame && first_pending)

endmodule

/* rtl/adf_back.sv */
// Back of the deframer: expands queued commands into result beats.
// Depends on adf_pkg and the shared assertion macros header.
`timescale 1ns / 1ps
`include "adts_frame_deframer_core_macros.svh"

module adf_back (
  input  logic                 clk,
  input  logic                 rst,
  input  adf_pkg::adf_cmd_t    head,
  input  adf_pkg::adf_qstat_t  qstat,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output adf_pkg::adf_result_t res
);

  logic pay_done;
  logic abort_done;
  logic head_valid;
  logic load;
  logic pend_pay;
  logic pend_abort;
  logic step_last;
  adf_pkg::adf_result_t nxt;

  assign head_valid = !qstat.empty;
  assign load       = head_valid && (!out_valid || out_ready);
  assign pend_pay   = head.has_pay && !pay_done;
  assign pend_abort = head.abort && !abort_done;
  assign pop        = load && step_last;

  // Order within one command: payload byte, abort, end of stream
  always_comb begin
    nxt       = '0;
    step_last = 1'b1;
    if (pend_pay) begin
      nxt.kind           = adf_pkg::KIND_PAYLOAD;
      nxt.payload_byte   = head.payload_byte;
      nxt.first_of_frame = head.first_of_frame;
      nxt.last_of_frame  = head.last_of_frame;
      nxt.payload_length = head.payload_length;
      nxt.info_valid     = head.info_valid;
      nxt.object_type    = head.object_type;
      nxt.rate_index     = head.rate_index;
      nxt.channel_setup  = head.channel_setup;
      nxt.freq_hz        = head.info_valid ? adf_pkg::rate_of(head.rate_index) : '0;
      nxt.run_last       = !head.eos;
      step_last          = !head.eos;
    end else if (pend_abort) begin
      nxt.kind  = adf_pkg::KIND_ABORT;
      step_last = 1'b0;
    end else begin
      nxt.kind     = adf_pkg::KIND_EOS;
      nxt.run_last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res <= nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      pay_done   <= 1'b0;
      abort_done <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        if (step_last) begin
          pay_done   <= 1'b0;
          abort_done <= 1'b0;
        end else if (pend_pay) begin
          pay_done <= 1'b1;
        end else begin
          abort_done <= 1'b1;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `ADF_CHECK_NEXT(a_abort_then_eos, clk, rst, out_valid && out_ready && res.kind == adf_pkg::KIND_ABORT, out_valid && res.kind == adf_pkg::KIND_EOS)
  `ADF_CHECK_IMPLY(a_done_matches_head, clk, rst, head_valid && (pay_done || abort_done), (!pay_done || head.has_pay) && (!abort_done || head.abort))

endmodule

/* rtl/adts_frame_deframer_core.sv */
// Top level of the ADTS deframer: byte stream in, payload/abort/end-of-stream beats out.
// Depends on adf_pkg, adf_front, adf_queue and adf_back.
//
//   channel | dir | payload                                        | notes
//   s_axis  | in  | tdata: in_byte; tlast: end_of_buffer           | one byte per beat
//   m_axis  | out | tdata: fields below; tuser: kind; tlast: last  | one result per beat
//
// Cycles: the front takes one byte per clock while the queue is not full and
// classifies it in that same cycle; a byte yields zero, one, two or three result
// beats. The back sends one beat per clock while m_axis_tready is high, and the
// four-entry command queue absorbs the extra beats while the front keeps accepting.
// Reset: synchronous, active high; clears window fill, frame state and the queue.
// Stalls: s_axis_tready drops only when the queue is full; m_axis_tdata holds
// while m_axis_tvalid is high and m_axis_tready is low.
`timescale 1ns / 1ps

module adts_frame_deframer_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic        s_axis_tlast,   // end_of_buffer
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] payload_byte, [8] first_of_frame, [21:9] payload_length,
  // [22] info_valid, [25:23] object_type, [29:26] rate_index,
  // [32:30] channel_setup, [49:33] freq_hz, [50] run_last, [55:51] zero
  output logic [adf_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  output logic [1:0]  m_axis_tuser,   // [1:0] kind
  output logic        m_axis_tlast    // last_of_frame
);

  adf_pkg::adf_cmd_t    push_cmd;
  adf_pkg::adf_cmd_t    head_cmd;
  adf_pkg::adf_qstat_t  qstat;
  adf_pkg::adf_result_t res;
  logic                 push;
  logic                 pop;

  // Front: hold the look-ahead window, hunt for sync, drop header bytes
  adf_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (s_axis_tvalid),
    .in_ready      (s_axis_tready),
    .in_byte       (s_axis_tdata),
    .end_of_buffer (s_axis_tlast),
    .qstat         (qstat),
    .push          (push),
    .cmd           (push_cmd)
  );

  // Queue: decouple classification from beat generation
  adf_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_cmd (push_cmd),
    .pop    (pop),
    .head   (head_cmd),
    .qstat  (qstat)
  );

  // Back: expand each command into beats and drive the output register
  adf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head_cmd),
    .qstat     (qstat),
    .pop       (pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .res       (res)
  );

  // Pack result fields, lowest field first, zero fill to whole bytes
  assign m_axis_tdata = {5'b0, res.run_last, res.freq_hz, res.channel_setup,
                         res.rate_index, res.object_type, res.info_valid,
                         res.payload_length, res.first_of_frame, res.payload_byte};
  assign m_axis_tuser = res.kind;
  assign m_axis_tlast = res.last_of_frame;

endmodule
